// ----- rtl/whac_pkg.sv -----
// ----------------------------------------------------------------------------
// whac_pkg
// Shared types, field widths and request codes of the weighted histogram
// accumulator.
// ----------------------------------------------------------------------------
package whac_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_BINS_DEF  = 1024;
    localparam int BIN_BITS_DEF  = 48;
    localparam int FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int REQ_BITS      = 2;
    localparam int SAMPLE_BITS   = 32;
    localparam int WEIGHT_BITS   = 32;
    localparam int SCALE_BITS    = 32;
    localparam int INDEX_BITS    = 10;
    localparam int COUNT_BITS    = 11;
    localparam int CONTENT_BITS  = 48;
    localparam int TOTAL_BITS    = 56;
    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;

    typedef logic [REQ_BITS-1:0] req_t;

    // Request codes
    localparam req_t REQ_FILL  = 2'd0;
    localparam req_t REQ_READ  = 2'd1;
    localparam req_t REQ_CLEAR = 2'd2;
    localparam req_t REQ_NONE  = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture the accepted item
        logic mul;      // form the bin product
        logic look;     // resolve the bin and read its entry
        logic commit;   // update the entry and total, load the result
        logic sweep;    // zero one entry of the bin store
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;     // result register can take a new item
        logic sweep_last;   // sweep is at the last entry
    } dp_sts_t;

endpackage

// ----- rtl/whac_cfg.sv -----
// ----------------------------------------------------------------------------
// whac_cfg
// APB register file: lower edge, bins per unit and bin count.
// ----------------------------------------------------------------------------
module whac_cfg
    import whac_pkg::*;
(
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [CFG_ADDR_BITS-1:0]        paddr,
    input  logic [CFG_DATA_BITS-1:0]        pwdata,
    output logic [CFG_DATA_BITS-1:0]        prdata,
    output logic                            pready,
    output logic signed [SAMPLE_BITS-1:0]   lower_edge,
    output logic [SCALE_BITS-1:0]           bins_per_unit,
    output logic [COUNT_BITS-1:0]           bin_count
);

    localparam logic [1:0] REG_LOWER_EDGE    = 2'd0;
    localparam logic [1:0] REG_BINS_PER_UNIT = 2'd1;
    localparam logic [1:0] REG_BIN_COUNT     = 2'd2;

    localparam logic [SCALE_BITS-1:0] BPU_RESET   = 32'd65536;
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = 11'd1024;

    logic signed [SAMPLE_BITS-1:0] lower_edge_reg;
    logic [SCALE_BITS-1:0]         bpu_reg;
    logic [COUNT_BITS-1:0]         bin_count_reg;
    logic                          wr_en;
    logic [1:0]                    reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Write registers on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_edge_reg <= '0;
            bpu_reg        <= BPU_RESET;
            bin_count_reg  <= COUNT_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_LOWER_EDGE:    lower_edge_reg <= pwdata;
                REG_BINS_PER_UNIT: bpu_reg        <= pwdata;
                REG_BIN_COUNT:     bin_count_reg  <= pwdata[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_sel)
            REG_LOWER_EDGE:    prdata = lower_edge_reg;
            REG_BINS_PER_UNIT: prdata = bpu_reg;
            REG_BIN_COUNT:     prdata = CFG_DATA_BITS'(bin_count_reg);
            default:           prdata = '0;
        endcase
    end

    assign lower_edge    = lower_edge_reg;
    assign bins_per_unit = bpu_reg;
    assign bin_count     = bin_count_reg;

endmodule

// ----- rtl/whac_ctrl.sv -----
// ----------------------------------------------------------------------------
// whac_ctrl
// Sequencer: steps each item through product, lookup and update, and walks
// the bin store on reset and on a clear request.
// ----------------------------------------------------------------------------
module whac_ctrl
    import whac_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  req_t    s_req,
    input  dp_sts_t sts,
    output logic    s_ready,
    output dp_cmd_t cmd
);

    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_LOOK = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;
    localparam logic [2:0] ST_WIPE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_INIT: begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = (s_req == REQ_CLEAR) ? ST_WIPE : ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_LOOK;
            end
            ST_LOOK: begin
                cmd.look   = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                // hold until the result register is free
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_WIPE: begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_UPD;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

// ----- rtl/whac_dp.sv -----
// ----------------------------------------------------------------------------
// whac_dp
// Datapath: bin product, bin store memory, saturating accumulators and the
// result register.
// ----------------------------------------------------------------------------
module whac_dp
    import whac_pkg::*;
#(
    parameter int NUM_BINS  = NUM_BINS_DEF,
    parameter int BIN_BITS  = BIN_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  dp_cmd_t                         cmd,
    output dp_sts_t                         sts,
    input  logic signed [SAMPLE_BITS-1:0]   lower_edge,
    input  logic [SCALE_BITS-1:0]           bins_per_unit,
    input  logic [COUNT_BITS-1:0]           bin_count,
    input  req_t                            req_type,
    input  logic signed [SAMPLE_BITS-1:0]   sample_value,
    input  logic signed [WEIGHT_BITS-1:0]   weight,
    input  logic [INDEX_BITS-1:0]           bin_index,
    input  logic                            m_ready,
    output logic                            m_valid,
    output logic [CONTENT_BITS-1:0]         bin_content,
    output logic [TOTAL_BITS-1:0]           total_sum,
    output logic                            accepted,
    output logic                            saturated
);

    localparam int IDX_W   = $clog2(NUM_BINS);
    localparam int CNT_W   = ($clog2(NUM_BINS + 1) > COUNT_BITS) ?
                             $clog2(NUM_BINS + 1) : COUNT_BITS;
    localparam int DIFF_W  = SAMPLE_BITS + 1;
    localparam int PROD_W  = SAMPLE_BITS + SCALE_BITS;
    localparam int BINQ_W  = PROD_W - 2 * FRAC_BITS;
    localparam int CMP_W   = (BINQ_W > CNT_W) ? BINQ_W : CNT_W;
    localparam int BSUM_W  = ((BIN_BITS > WEIGHT_BITS) ? BIN_BITS : WEIGHT_BITS) + 1;
    localparam int TSUM_W  = TOTAL_BITS + 1;
    localparam int WIDE_W  = 64;

    // Captured item
    req_t                          req_reg;
    logic signed [WEIGHT_BITS-1:0] weight_reg;
    logic [INDEX_BITS-1:0]         idx_reg;
    logic signed [DIFF_W-1:0]      diff_reg;
    logic [PROD_W-1:0]             prod_reg;
    logic                          hit_reg;
    logic [IDX_W-1:0]              addr_reg;
    logic signed [BIN_BITS-1:0]    rd_data_reg;

    // Bin store and sweep
    logic [BIN_BITS-1:0]           mem [NUM_BINS];
    logic [IDX_W-1:0]              sweep_cnt_reg;
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    logic [BIN_BITS-1:0]           wr_data;

    // Accumulators and result
    logic signed [TOTAL_BITS-1:0]  total_reg;
    logic signed [TOTAL_BITS-1:0]  total_next;
    logic                          m_valid_reg;
    logic [CONTENT_BITS-1:0]       content_reg;
    logic [TOTAL_BITS-1:0]         total_out_reg;
    logic                          acc_reg;
    logic                          sat_reg;

    // Lookup logic
    logic [CNT_W-1:0]              cnt_eff;
    logic [CNT_W-1:0]              idx_ext;
    logic [BINQ_W-1:0]             bin_q;
    logic                          in_range;
    logic                          fill_hit;
    logic                          read_hit;
    logic                          look_hit;
    logic [IDX_W-1:0]              look_addr;

    // Update logic
    logic signed [BSUM_W-1:0]      bsum;
    logic                          bin_fits;
    logic signed [BIN_BITS-1:0]    new_bin;
    logic signed [TSUM_W-1:0]      tsum;
    logic                          total_fits;
    logic signed [TOTAL_BITS-1:0]  new_total;
    logic signed [WIDE_W-1:0]      new_bin_wide;
    logic signed [WIDE_W-1:0]      rd_wide;
    logic                          fill_commit;
    logic [CONTENT_BITS-1:0]       res_content;
    logic [TOTAL_BITS-1:0]         res_total;
    logic                          res_acc;
    logic                          res_sat;
    logic [PROD_W-1:0]             prod_c;

    // Capture the item and form the offset from the lower edge
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg    <= req_type;
            weight_reg <= weight;
            idx_reg    <= bin_index;
            diff_reg   <= DIFF_W'(sample_value) - DIFF_W'(lower_edge);
        end
    end

    // Scale the offset by bins per unit
    assign prod_c = diff_reg[SAMPLE_BITS-1:0] * bins_per_unit;

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= prod_c;
        end
    end

    // Resolve the bin and whether it lies inside the bins in use
    assign cnt_eff  = (CNT_W'(bin_count) > CNT_W'(NUM_BINS)) ? CNT_W'(NUM_BINS)
                                                             : CNT_W'(bin_count);
    assign idx_ext  = CNT_W'(idx_reg);
    assign bin_q    = prod_reg[PROD_W-1:2*FRAC_BITS];
    assign in_range = (bins_per_unit == '0) || !diff_reg[DIFF_W-1];
    assign fill_hit = in_range && (CMP_W'(bin_q) < CMP_W'(cnt_eff));
    assign read_hit = idx_ext < cnt_eff;

    always_comb begin
        unique case (req_reg)
            REQ_FILL: begin
                look_hit  = fill_hit;
                look_addr = bin_q[IDX_W-1:0];
            end
            REQ_READ: begin
                look_hit  = read_hit;
                look_addr = idx_ext[IDX_W-1:0];
            end
            default: begin
                look_hit  = 1'b0;
                look_addr = idx_ext[IDX_W-1:0];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.look) begin
            hit_reg  <= look_hit;
            addr_reg <= look_addr;
        end
    end

    // Saturating bin update
    assign bsum     = BSUM_W'(rd_data_reg) + BSUM_W'(weight_reg);
    assign bin_fits = (&bsum[BSUM_W-1:BIN_BITS-1]) || !(|bsum[BSUM_W-1:BIN_BITS-1]);
    assign new_bin  = bin_fits ? bsum[BIN_BITS-1:0] :
                      (bsum[BSUM_W-1] ? {1'b1, {(BIN_BITS-1){1'b0}}}
                                      : {1'b0, {(BIN_BITS-1){1'b1}}});

    // Saturating total update
    assign tsum       = TSUM_W'(total_reg) + TSUM_W'(weight_reg);
    assign total_fits = (tsum[TSUM_W-1] == tsum[TOTAL_BITS-1]);
    assign new_total  = total_fits ? tsum[TOTAL_BITS-1:0] :
                        (tsum[TSUM_W-1] ? {1'b1, {(TOTAL_BITS-1){1'b0}}}
                                        : {1'b0, {(TOTAL_BITS-1){1'b1}}});

    assign new_bin_wide = WIDE_W'(new_bin);
    assign rd_wide      = WIDE_W'(rd_data_reg);
    assign fill_commit  = cmd.commit && (req_reg == REQ_FILL) && hit_reg;

    // Result of the current item
    always_comb begin
        res_content = '0;
        res_total   = total_reg;
        res_acc     = 1'b0;
        res_sat     = 1'b0;
        total_next  = total_reg;
        unique case (req_reg)
            REQ_FILL: begin
                if (hit_reg) begin
                    res_content = new_bin_wide[CONTENT_BITS-1:0];
                    res_total   = new_total;
                    res_acc     = 1'b1;
                    res_sat     = !bin_fits || !total_fits;
                    total_next  = new_total;
                end
            end
            REQ_READ: begin
                if (hit_reg) begin
                    res_content = rd_wide[CONTENT_BITS-1:0];
                    res_acc     = 1'b1;
                end
            end
            REQ_CLEAR: begin
                res_total  = '0;
                total_next = '0;
            end
            default: ;
        endcase
    end

    // Bin store: one write port, one registered read port
    assign wr_en   = cmd.sweep || fill_commit;
    assign wr_addr = cmd.sweep ? sweep_cnt_reg : addr_reg;
    assign wr_data = cmd.sweep ? '0 : new_bin;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.look) begin
            rd_data_reg <= mem[look_addr];
        end
    end

    // Advance the clearing sweep
    assign sts.sweep_last = (sweep_cnt_reg == IDX_W'(NUM_BINS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_cnt_reg <= '0;
        end else if (cmd.sweep) begin
            sweep_cnt_reg <= sts.sweep_last ? '0 : sweep_cnt_reg + 1'b1;
        end
    end

    // Running total
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
        end else if (cmd.commit) begin
            total_reg <= total_next;
        end
    end

    // Result register
    assign sts.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            content_reg   <= res_content;
            total_out_reg <= res_total;
            acc_reg       <= res_acc;
            sat_reg       <= res_sat;
        end
    end

    assign m_valid     = m_valid_reg;
    assign bin_content = content_reg;
    assign total_sum   = total_out_reg;
    assign accepted    = acc_reg;
    assign saturated   = sat_reg;

endmodule

// ----- rtl/weighted_histogram_accumulator_core.sv -----
// ----------------------------------------------------------------------------
// weighted_histogram_accumulator_core
// One-dimensional weighted histogram with fill, read and clear requests.
// ----------------------------------------------------------------------------
// A fill or read item is accepted, goes through offset capture, a 32x32 bin
// product, a registered read of the bin store and a saturating update, and
// its result is loaded once the result register is free; the next item is
// taken in the cycle after that, as the sequencer steps one item at a time
// through the product, the registered bin read and the update. A clear walks
// the bin store one entry per cycle and loads its result before the next
// acceptance. After reset the same clearing pass runs with s_tready low;
// configuration writes are taken at any time. The result register lets the
// next item in while a result waits for m_tready, but a new result is held
// back until the previous one is taken.
module weighted_histogram_accumulator_core
    import whac_pkg::*;
#(
    parameter int NUM_BINS  = NUM_BINS_DEF,
    parameter int BIN_BITS  = BIN_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // request channel
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // tdata: sample_value[31:0], weight[63:32], bin_index[73:64], zero pad
    input  logic [79:0]                 s_tdata,
    // tuser: req_type[1:0]
    input  logic [1:0]                  s_tuser,
    // result channel
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // tdata: bin_content[47:0], total_sum[103:48]
    output logic [103:0]                m_tdata,
    // tuser: accepted[0], saturated[1]
    output logic [1:0]                  m_tuser,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [CFG_ADDR_BITS-1:0]    paddr,
    input  logic [CFG_DATA_BITS-1:0]    pwdata,
    output logic [CFG_DATA_BITS-1:0]    prdata,
    output logic                        pready
);

    logic signed [SAMPLE_BITS-1:0] lower_edge;
    logic [SCALE_BITS-1:0]         bins_per_unit;
    logic [COUNT_BITS-1:0]         bin_count;
    dp_cmd_t                       cmd;
    dp_sts_t                       sts;
    logic [CONTENT_BITS-1:0]       bin_content;
    logic [TOTAL_BITS-1:0]         total_sum;
    logic                          accepted;
    logic                          saturated;

    whac_cfg u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .lower_edge    (lower_edge),
        .bins_per_unit (bins_per_unit),
        .bin_count     (bin_count)
    );

    whac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_req   (s_tuser),
        .sts     (sts),
        .s_ready (s_tready),
        .cmd     (cmd)
    );

    whac_dp #(
        .NUM_BINS  (NUM_BINS),
        .BIN_BITS  (BIN_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .lower_edge    (lower_edge),
        .bins_per_unit (bins_per_unit),
        .bin_count     (bin_count),
        .req_type      (s_tuser),
        .sample_value  (s_tdata[31:0]),
        .weight        (s_tdata[63:32]),
        .bin_index     (s_tdata[73:64]),
        .m_ready       (m_tready),
        .m_valid       (m_tvalid),
        .bin_content   (bin_content),
        .total_sum     (total_sum),
        .accepted      (accepted),
        .saturated     (saturated)
    );

    assign m_tdata = {total_sum, bin_content};
    assign m_tuser = {saturated, accepted};

    // One item at a time: no acceptance right after an acceptance
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while another is in flight");

    // A result is loaded only into a free result register
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> sts.out_free)
        else $error("result loaded over a pending result");

    // A clipped fill always landed in a bin
    a_sat_accepted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> m_tuser[0])
        else $error("saturated flag without accepted flag");

    // No item is taken while the bin store is being cleared
    a_sweep_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sweep |-> !s_tready)
        else $error("item accepted during the clearing sweep");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the weighted histogram accumulator core. A bin
// tracker mirrors the bin store and running total, predicts one result per
// accepted request, and compares each result from the block field by field.
// Directed requests come first, then random requests under several register
// settings, with stalls on both channels and a burst of full-scale fills
// onto one bin.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import whac_pkg::*;

    localparam int NBINS           = NUM_BINS_DEF;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int BURST_FILLS     = 30;
    localparam int MAX_PRINTED     = 200;

    typedef enum int {
        REG_LOWER_EDGE    = 0,
        REG_BINS_PER_UNIT = 1,
        REG_BIN_COUNT     = 2
    } cfg_reg_e;

    typedef struct {
        logic signed [CONTENT_BITS-1:0] content;
        logic signed [TOTAL_BITS-1:0]   total;
        logic                           accepted;
        logic                           saturated;
    } bin_result_t;

    // Mirror of the bin store, the total and the registers
    class hist_tracker;
        logic signed [SAMPLE_BITS-1:0]  lower_edge;
        logic [SCALE_BITS-1:0]          bins_per_unit;
        logic [COUNT_BITS-1:0]          bin_count;
        logic signed [CONTENT_BITS-1:0] bin_store [NBINS];
        logic signed [TOTAL_BITS-1:0]   weight_total;
        bin_result_t                    pending_results [$];
        int                             mismatches;

        function new();
            lower_edge    = '0;
            bins_per_unit = 32'd65536;
            bin_count     = 11'd1024;
            foreach (bin_store[i]) bin_store[i] = '0;
            weight_total  = '0;
            mismatches    = 0;
        endfunction

        function void set_register(cfg_reg_e which, logic [31:0] value);
            case (which)
                REG_LOWER_EDGE:    lower_edge    = value;
                REG_BINS_PER_UNIT: bins_per_unit = value;
                REG_BIN_COUNT:     bin_count     = value[COUNT_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Bins in use, limited to the size of the store
        function int used_bins();
            return (bin_count > NBINS) ? NBINS : int'(bin_count);
        endfunction

        // Add with clipping to a signed field of the given width
        function longint sat_add(longint acc, longint w, int bits, inout bit clip);
            longint hi, lo, sum;
            hi  = (longint'(1) <<< (bits - 1)) - 1;
            lo  = -hi - 1;
            sum = acc + w;
            if (sum > hi) begin
                clip = 1'b1;
                sum  = hi;
            end else if (sum < lo) begin
                clip = 1'b1;
                sum  = lo;
            end
            return sum;
        endfunction

        // Update the mirror for one request and queue its result
        function void apply_request(req_t req, logic signed [31:0] sample,
                                    logic signed [31:0] weight, logic [9:0] index);
            bin_result_t      r;
            longint           diff;
            longint unsigned  prod;
            longint unsigned  bin;
            bit               hit;
            bit               clip;
            r.content   = '0;
            r.accepted  = 1'b0;
            r.saturated = 1'b0;
            case (req)
                REQ_FILL: begin
                    diff = longint'(sample) - longint'(lower_edge);
                    hit  = 1'b0;
                    bin  = 0;
                    if (bins_per_unit == 0) begin
                        hit = 1'b1;
                    end else if (diff >= 0) begin
                        prod = longint'(diff) * longint'({32'd0, bins_per_unit});
                        bin  = prod >> (2 * FRAC_BITS_DEF);
                        hit  = 1'b1;
                    end
                    if (hit && bin < longint'(used_bins())) begin
                        clip           = 1'b0;
                        bin_store[bin] = sat_add(bin_store[bin], weight, CONTENT_BITS, clip);
                        weight_total   = sat_add(weight_total, weight, TOTAL_BITS, clip);
                        r.content      = bin_store[bin];
                        r.accepted     = 1'b1;
                        r.saturated    = clip;
                    end
                end
                REQ_READ: begin
                    if (int'(index) < used_bins()) begin
                        r.content  = bin_store[index];
                        r.accepted = 1'b1;
                    end
                end
                REQ_CLEAR: begin
                    foreach (bin_store[i]) bin_store[i] = '0;
                    weight_total = '0;
                end
                default: ;
            endcase
            r.total = weight_total;
            pending_results.push_back(r);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            if (mismatches < MAX_PRINTED)
                $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
            mismatches++;
        endtask

        // Compare one result with the oldest prediction
        task compare_result(logic [103:0] data, logic [1:0] flags);
            bin_result_t want;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", data[63:0], 64'd0);
                return;
            end
            want = pending_results.pop_front();
            if (data[47:0] !== want.content)
                report_mismatch("bin_content", data[47:0], want.content);
            if (data[103:48] !== want.total)
                report_mismatch("total_sum", data[103:48], want.total);
            if (flags[0] !== want.accepted)
                report_mismatch("accepted", flags[0], want.accepted);
            if (flags[1] !== want.saturated)
                report_mismatch("saturated", flags[1], want.saturated);
        endtask
    endclass

    logic                     aclk     = 1'b0;
    logic                     aresetn  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [79:0]              s_tdata  = '0;
    logic [1:0]               s_tuser  = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [103:0]             m_tdata;
    logic [1:0]               m_tuser;
    logic                     psel     = 1'b0;
    logic                     penable  = 1'b0;
    logic                     pwrite   = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr    = '0;
    logic [CFG_DATA_BITS-1:0] pwdata   = '0;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    hist_tracker sb;
    int          snd_idle_pct = 8;
    int          rcv_idle_pct = 71;

    weighted_histogram_accumulator_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 aclk = ~aclk;

    // Hold reset at the start, then release it
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Take results and stall the result channel at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.compare_result(m_tdata, m_tuser);
        m_tready <= (int'($urandom_range(0, 99)) >= rcv_idle_pct);
    end

    // Drive one request item and wait for its acceptance
    task automatic send_item(req_t req, logic [31:0] sample, logic [31:0] weight,
                             logic [9:0] index);
        while (int'($urandom_range(0, 99)) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, index, weight, sample};
        s_tuser  <= req;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.apply_request(req, sample, weight, index);
    endtask

    // Write one register through a setup and an access cycle
    task automatic cfg_write(cfg_reg_e which, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_BITS'(4 * int'(which));
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_register(which, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Stop sending and wait until every predicted result is in
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_phase(logic [31:0] edge_val, logic [31:0] scale, logic [31:0] count);
        drain();
        cfg_write(REG_LOWER_EDGE, edge_val);
        cfg_write(REG_BINS_PER_UNIT, scale);
        cfg_write(REG_BIN_COUNT, count);
    endtask

    // Mostly fills aimed inside the range, plus reads, clears and noise
    task automatic random_item();
        int unsigned pick;
        int          count;
        int          small_w;
        longint      span;
        longint      offset;
        longint      target;
        logic [31:0] sample;
        logic [31:0] weight;
        logic [9:0]  index;
        req_t        req;
        pick    = $urandom_range(0, 99);
        count   = sb.used_bins();
        sample  = $urandom;
        index   = 10'($urandom);
        small_w = int'($urandom_range(0, 255)) - 128;
        case ($urandom_range(0, 9))
            0:       weight = 32'h7FFF_FFFF;
            1:       weight = 32'h8000_0000;
            2:       weight = small_w;
            default: weight = $urandom;
        endcase
        req = REQ_FILL;
        if (pick < 58) begin
            // aim at a bin, sometimes just past either end
            if (sb.bins_per_unit != 0) begin
                span = (longint'(count) << 32) / longint'({32'd0, sb.bins_per_unit});
                if (span < 1) span = 1;
                case ($urandom_range(0, 9))
                    0:       offset = span - 1;
                    1:       offset = span;
                    2:       offset = -1;
                    default: offset = longint'({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF)
                                      % span;
                endcase
                target = longint'(sb.lower_edge) + offset;
                if (target >= -(longint'(1) <<< 31) && target < (longint'(1) <<< 31))
                    sample = target[31:0];
            end
        end else if (pick < 70) begin
            req = REQ_FILL;
        end else if (pick < 91) begin
            req = REQ_READ;
            if (pick < 84 && count > 0)
                index = 10'($urandom_range(0, count - 1));
        end else if (pick < 94) begin
            req = REQ_CLEAR;
        end else begin
            req = REQ_NONE;
        end
        send_item(req, sample, weight, index);
    endtask

    task automatic run_random(int n);
        repeat (n) random_item();
    endtask

    // Stimulus
    initial begin
        sb = new();
        wait (aresetn);
        @(posedge aclk);

        // Edges of the range, extremes of the fields, every request type
        send_item(REQ_FILL,  32'h0000_0000, 32'h7FFF_FFFF, 10'h000);
        send_item(REQ_FILL,  32'h0000_FFFF, 32'h0000_0001, 10'h3FF);
        send_item(REQ_FILL,  32'h03FF_FFFF, 32'h8000_0000, 10'h000);
        send_item(REQ_FILL,  32'h0400_0000, 32'h0001_0000, 10'h155);
        send_item(REQ_FILL,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 10'h2AA);
        send_item(REQ_FILL,  32'h8000_0000, 32'h0001_0000, 10'h000);
        send_item(REQ_FILL,  32'hFFFF_FFFF, 32'h0001_0000, 10'h3FF);
        send_item(REQ_READ,  32'h0000_0000, 32'h0000_0000, 10'h000);
        send_item(REQ_READ,  32'h0000_0000, 32'h0000_0000, 10'h3FF);
        send_item(REQ_READ,  32'h0000_0000, 32'h0000_0000, 10'h200);
        send_item(REQ_READ,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h001);
        send_item(REQ_NONE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF);
        send_item(REQ_FILL,  32'h0005_0000, 32'hFFFF_FFFF, 10'h000);
        send_item(REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF);
        send_item(REQ_READ,  32'h0000_0000, 32'h0000_0000, 10'h000);
        send_item(REQ_READ,  32'h0000_0000, 32'h0000_0000, 10'h3FF);
        send_item(REQ_FILL,  32'h0002_8000, 32'h8000_0000, 10'h000);
        send_item(REQ_FILL,  32'h0002_8000, 32'h8000_0000, 10'h000);
        send_item(REQ_READ,  32'h0000_0000, 32'h0000_0000, 10'h002);
        run_random(ITEMS_PER_PHASE);

        // Lowest edge with the finest binning
        set_phase(32'h8000_0000, 32'hFFFF_FFFF, 32'd1024);
        run_random(ITEMS_PER_PHASE);

        // Swap the stalls: zero scale maps every sample to the single bin
        snd_idle_pct = 71;
        rcv_idle_pct = 8;
        set_phase(32'h7FFF_FFFF, 32'd0, 32'd1);
        run_random(ITEMS_PER_PHASE);

        // Bin count beyond the store size
        set_phase(32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000,
                  32'($urandom_range(32'h0000_1000, 32'h0010_0000)), 32'd2047);
        run_random(ITEMS_PER_PHASE);

        // No stalls: no bin in use drops every fill and every read
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        set_phase($urandom, 32'd1, 32'd0);
        run_random(ITEMS_PER_PHASE);

        set_phase($urandom, $urandom, 32'($urandom_range(1, 1024)));
        run_random(ITEMS_PER_PHASE);

        // Pile full-scale weights onto one bin, then pull it back and clear
        set_phase(32'd0, 32'd65536, 32'd1024);
        send_item(REQ_CLEAR, 32'd0, 32'd0, 10'd0);
        repeat (BURST_FILLS) send_item(REQ_FILL, 32'h0003_0000, 32'h7FFF_FFFF, 10'd0);
        send_item(REQ_READ,  32'd0, 32'd0, 10'd3);
        send_item(REQ_FILL,  32'h0003_0000, 32'h8000_0000, 10'd0);
        send_item(REQ_FILL,  32'h0003_0000, 32'h7FFF_FFFF, 10'd0);
        send_item(REQ_CLEAR, 32'd0, 32'd0, 10'd0);
        send_item(REQ_READ,  32'd0, 32'd0, 10'd3);

        drain();
        repeat (16) @(posedge aclk);
        if (sb.pending_results.size() != 0)
            sb.report_mismatch("results never arrived", sb.pending_results.size(), 64'd0);
        if (sb.mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #40_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

// ----- weighted_histogram_accumulator_core.f -----
rtl/whac_pkg.sv
rtl/whac_cfg.sv
rtl/whac_ctrl.sv
rtl/whac_dp.sv
rtl/weighted_histogram_accumulator_core.sv
tb/tb_top.sv
